>>> src/ddo_pkg.sv
`default_nettype none

package ddo_pkg;

   // Item kinds carried on req_tuser
   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_RESET  = 1'b1
   } op_type;

   localparam int          MaxSteps     = 24;
   localparam int          StepIdxW     = 5;
   localparam int          RotW         = 34;
   localparam int          ApmW         = 20;
   localparam logic [19:0] ApmReset     = 20'd52151;
   // Vector start value: reciprocal of the aggregate CORDIC gain in Q2.30
   localparam logic signed [33:0] CordicGain = 34'sd652032874;

   // Rotator result handed to the sequencer
   typedef struct packed {
      logic               done;
      logic signed [31:0] cos_val;
      logic signed [31:0] sin_val;
   } rot_out_type;

   // Arctangent of 2^-i in 32-bit binary angle units
   function automatic logic [31:0] atan_bau(input logic [StepIdxW-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10681886;
         5'd7:    v = 32'd5342293;
         5'd8:    v = 32'd2671187;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> src/ddo_cordic.sv
`default_nettype none

module ddo_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [15:0]       angle,
   output ddo_pkg::rot_out_type   rot_out
);

   localparam int CntW = $clog2(CORDIC_STEPS);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic                              flip_ff, flip_in;
   logic [CntW-1:0]                   count_ff, count_in;
   logic signed [ddo_pkg::RotW-1:0]   x_ff, x_in;
   logic signed [ddo_pkg::RotW-1:0]   y_ff, y_in;
   logic signed [ddo_pkg::RotW-1:0]   z_ff, z_in;
   logic signed [ddo_pkg::RotW-1:0]   z_start;
   logic signed [ddo_pkg::RotW-1:0]   x_sh, y_sh, step_ang;
   logic signed [ddo_pkg::RotW-1:0]   x_out, y_out;

   // Fold the start angle into +-pi/2, one micro-rotation per cycle after that
   always_comb begin
      z_start  = {{2{angle[15]}}, angle, 16'b0};
      x_sh     = x_ff >>> count_ff;
      y_sh     = y_ff >>> count_ff;
      step_ang = {2'b00, ddo_pkg::atan_bau(ddo_pkg::StepIdxW'(count_ff))};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      flip_in  = flip_ff;
      count_in = count_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         x_in     = ddo_pkg::CordicGain;
         y_in     = '0;
         flip_in  = 1'b0;
         z_in     = z_start;
         if (z_start > 34'sd1073741824) begin
            z_in    = z_start - 34'sd2147483648;
            flip_in = 1'b1;
         end else if (z_start < -34'sd1073741824) begin
            z_in    = z_start + 34'sd2147483648;
            flip_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!z_ff[ddo_pkg::RotW-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - step_ang;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + step_ang;
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CntW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff  <= flip_in;
      count_ff <= count_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
   end

   // Undo the half-turn fold on the way out
   always_comb begin
      x_out           = flip_ff ? -x_ff : x_ff;
      y_out           = flip_ff ? -y_ff : y_ff;
      rot_out.done    = done_ff;
      rot_out.cos_val = x_out[31:0];
      rot_out.sin_val = y_out[31:0];
   end

endmodule

`default_nettype wire

>>> src/ddo_mul.sv
`default_nettype none

module ddo_mul (
   input  wire logic               clock,
   input  wire logic signed [31:0] mul_a,
   input  wire logic signed [32:0] mul_b,
   output logic signed [64:0]      prod_ff
);

   logic signed [64:0] prod_in;

   // Register the product before anything uses it
   always_comb begin
      prod_in = 65'(mul_a) * 65'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

>>> src/diff_drive_odometry.sv
`default_nettype none

// Differential-drive odometry. Each update beat carries the cumulative right
// and left wheel distances (signed Q15.16 m); the block forms the wheel steps
// against the previous distances, moves x/y by the centre step along the old
// heading (saturating) and turns the heading by the wheel difference times
// csr_wdata's angle_per_metre (wrapping 16-bit binary angle). A reset-pose beat
// zeroes pose and previous distances. One result beat follows every request.
// An update runs the iterative CORDIC, one micro-rotation per cycle, then
// three passes through the single shared multiplier and the heading step; a
// reset-pose beat goes from acceptance straight to ST_DONE. req_tready stays
// low while an item is in work and rises together with rsp_tvalid, so a new
// request is taken only once the last result is queued in the output register;
// a finished result waits there while the next request is taken.
module diff_drive_odometry #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [19:0] csr_wdata,     // angle_per_metre
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,     // right_distance[31:0], left_distance[63:32]
   input  wire logic [0:0]  req_tuser,     // op[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata      // pose_x[31:0], pose_y[63:32], heading[79:64]
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_T,
      ST_HEAD,
      ST_DONE
   } state_type;

   state_type                   state_ff;
   logic                        rsp_tvalid_ff;
   logic [79:0]                 out_ff;
   logic [ddo_pkg::ApmW-1:0]    apm_ff;
   logic signed [31:0]          pos_x_ff, pos_x_in;
   logic signed [31:0]          pos_y_ff, pos_y_in;
   logic [15:0]                 head_ff;
   logic [31:0]                 last_r_ff, last_l_ff;
   logic signed [31:0]          dc_ff;
   logic [31:0]                 diff_ff;

   logic                        accept, out_free;
   ddo_pkg::op_type             req_op;
   logic [31:0]                 dr, dl;
   logic signed [32:0]          wheel_sum;
   logic signed [31:0]          mul_a;
   logic signed [32:0]          mul_b;
   logic signed [64:0]          prod_ff;
   logic signed [64:0]          prod_rnd;
   logic signed [35:0]          sat_sum;
   logic signed [31:0]          sat_val;
   logic [31:0]                 turn_rnd;
   ddo_pkg::rot_out_type        rot_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_op     = ddo_pkg::op_type'(req_tuser[0]);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = out_ff;

   // Wheel steps and their sum for the centre step
   always_comb begin
      dr        = req_tdata[31:0] - last_r_ff;
      dl        = req_tdata[63:32] - last_l_ff;
      wheel_sum = 33'(signed'(dr)) + 33'(signed'(dl));
   end

   ddo_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && (req_op == ddo_pkg::OP_UPDATE)),
      .angle   (head_ff),
      .rot_out (rot_out)
   );

   // Select operands for the shared multiplier
   always_comb begin
      mul_a = dc_ff;
      mul_b = 33'(rot_out.cos_val);
      unique case (state_ff)
         ST_MUL_X: begin
            mul_a = dc_ff;
            mul_b = 33'(rot_out.cos_val);
         end
         ST_MUL_Y: begin
            mul_a = dc_ff;
            mul_b = 33'(rot_out.sin_val);
         end
         ST_MUL_T: begin
            mul_a = signed'(diff_ff);
            mul_b = signed'({13'b0, apm_ff});
         end
         default: begin
            mul_a = dc_ff;
            mul_b = 33'(rot_out.cos_val);
         end
      endcase
   end

   ddo_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // Round off the Q2.30 factor's fraction bits and saturate into the position under update
   always_comb begin
      prod_rnd = prod_ff + 65'sd536870912;
      sat_sum  = 36'((state_ff == ST_MUL_Y) ? pos_x_ff : pos_y_ff)
               + 36'(signed'(prod_rnd[64:30]));
      if (sat_sum > 36'sd2147483647) begin
         sat_val = 32'sh7fffffff;
      end else if (sat_sum < -36'sd2147483648) begin
         sat_val = 32'sh80000000;
      end else begin
         sat_val = sat_sum[31:0];
      end
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (state_ff == ST_MUL_Y) begin
         pos_x_in = sat_val;
      end
      if (state_ff == ST_MUL_T) begin
         pos_y_in = sat_val;
      end
      // Clear the position on a reset-pose beat
      if (accept && (req_op == ddo_pkg::OP_RESET)) begin
         pos_x_in = '0;
         pos_y_in = '0;
      end
      turn_rnd = prod_ff[31:0] + 32'h0000_8000;
   end

   // Sequencer, pose state and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         apm_ff        <= ddo_pkg::ApmReset;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         head_ff       <= '0;
         last_r_ff     <= '0;
         last_l_ff     <= '0;
      end else begin
         if (csr_we) begin
            apm_ff <= csr_wdata;
         end
         // Raise valid as a result is queued, drop it once taken
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_op == ddo_pkg::OP_RESET) begin
                     head_ff   <= '0;
                     last_r_ff <= '0;
                     last_l_ff <= '0;
                     state_ff  <= ST_DONE;
                  end else begin
                     last_r_ff <= req_tdata[31:0];
                     last_l_ff <= req_tdata[63:32];
                     dc_ff     <= wheel_sum[32:1];
                     diff_ff   <= dr - dl;
                     state_ff  <= ST_CORDIC;
                  end
               end
            end
            ST_CORDIC: begin
               if (rot_out.done) begin
                  state_ff <= ST_MUL_X;
               end
            end
            ST_MUL_X: state_ff <= ST_MUL_Y;
            ST_MUL_Y: state_ff <= ST_MUL_T;
            ST_MUL_T: state_ff <= ST_HEAD;
            ST_HEAD: begin
               head_ff  <= head_ff + turn_rnd[31:16];
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  out_ff   <= {head_ff, pos_y_ff, pos_x_ff};
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Accepting an item closes the input until its result is queued
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken while an item is in work");

   // The rotator only finishes while the sequencer waits for it
   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      rot_out.done |-> (state_ff == ST_CORDIC))
      else $error("rotator finished outside its wait state");

   // A new result appears only as the sequencer returns to idle
   a_rsp_with_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result raised while an item is still in work");

   // A reset-pose beat leaves the pose at zero
   a_reset_pose_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == ddo_pkg::OP_RESET)) |=>
         (pos_x_ff == '0) && (pos_y_ff == '0) && (head_ff == '0))
      else $error("reset-pose beat did not clear the pose");

endmodule

`default_nettype wire
